>>> hw/rtl/dict_enc_pkg.sv
// Shared constants, codes and control/status bundles of the dictionary encoder.
package dict_enc_pkg;

  localparam int DICT_ENTRIES_DEF = 256;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 64;
  localparam int KEY_W    = 8;
  localparam int STATUS_W = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Result kinds picked by the controller
  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_INS_OK = 3'd0;
  localparam logic [RES_W-1:0] RES_FULL   = 3'd1;
  localparam logic [RES_W-1:0] RES_ABSENT = 3'd2;
  localparam logic [RES_W-1:0] RES_ENC_OK = 3'd3;
  localparam logic [RES_W-1:0] RES_DEC_OK = 3'd4;

  typedef struct packed {
    logic             latch_in;
    logic             insert_wr;
    logic             scan_start;
    logic             scan_step;
    logic             dec_read;
    logic             res_load;
    logic [RES_W-1:0] res_sel;
    logic             push;
  } dict_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             full;
    logic             key_ok;
    logic             hit;
    logic             scan_end;
    logic             out_free;
  } dict_stat_t;

endpackage

>>> hw/rtl/dictionary_encoder_core.sv
// Top level of the dictionary encoder: controller plus datapath.
//
// Usage: one input beat (in_command, in_value, in_key) yields exactly one
// result beat (out_key_out, out_value_out, out_status), in order. Both
// channels use valid/ready; a beat moves when valid and ready are high.
//   insert: value stored at the next free key, key returned; full -> status 2.
//   encode: lowest key holding the value, or status 1 when absent.
//   decode: value at the key, or status 1 when the key was never written.
// From accept, a beat passes an execute step and then a push step; decode adds
// a wait for the registered RAM read, and encode a scan that ends at the first
// hit or after the last stored entry. Encode walks the table one entry per
// cycle through the single read port of the entry RAM, which sets its cost.
// The block works on one beat at a time; the next beat is taken in the cycle
// after its predecessor's result is loaded into the output register.
// The output register holds a finished result while the receiver stalls;
// the next beat is still accepted and worked on, and its result waits in a
// result register until the output frees up.
// Reset empties the table (entry count to zero) and drops any pending beat;
// entry contents are not cleared since only written entries are read.
module dictionary_encoder_core #(
  parameter int DICT_ENTRIES = dict_enc_pkg::DICT_ENTRIES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [dict_enc_pkg::CMD_W-1:0]          in_command,
  input  logic signed [dict_enc_pkg::VALUE_W-1:0] in_value,
  input  logic [dict_enc_pkg::KEY_W-1:0]          in_key,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [dict_enc_pkg::KEY_W-1:0]          out_key_out,
  output logic signed [dict_enc_pkg::VALUE_W-1:0] out_value_out,
  output logic [dict_enc_pkg::STATUS_W-1:0]       out_status
);

  // Command and status bundles between controller and datapath
  dict_enc_pkg::dict_cmd_t  cmd;
  dict_enc_pkg::dict_stat_t stat;

  dict_enc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  dict_enc_dp #(
    .DICT_ENTRIES(DICT_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_command   (in_command),
    .in_value     (in_value),
    .in_key       (in_key),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key_out  (out_key_out),
    .out_value_out(out_value_out),
    .out_status   (out_status)
  );

endmodule

>>> hw/rtl/dict_enc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dict_enc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/dict_enc_ctrl.sv
// Controller state machine of the dictionary encoder.
module dict_enc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  dict_enc_pkg::dict_stat_t stat,
  output dict_enc_pkg::dict_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_PUSH   = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_PUSH;
        unique case (stat.command)
          dict_enc_pkg::CMD_INSERT: begin
            if (stat.full) begin
              cmd.res_sel = dict_enc_pkg::RES_FULL;
            end else begin
              cmd.insert_wr = 1'b1;
              cmd.res_sel   = dict_enc_pkg::RES_INS_OK;
            end
          end
          dict_enc_pkg::CMD_ENCODE: begin
            cmd.res_load   = 1'b0;
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          dict_enc_pkg::CMD_DECODE: begin
            if (stat.key_ok) begin
              cmd.res_load = 1'b0;
              cmd.dec_read = 1'b1;
              state_nxt    = S_RDWAIT;
            end else begin
              cmd.res_sel = dict_enc_pkg::RES_ABSENT;
            end
          end
          default: begin
            cmd.res_sel = dict_enc_pkg::RES_ABSENT;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = dict_enc_pkg::RES_ENC_OK;
          state_nxt    = S_PUSH;
        end else if (stat.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = dict_enc_pkg::RES_ABSENT;
          state_nxt    = S_PUSH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = dict_enc_pkg::RES_DEC_OK;
        state_nxt    = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A scan never starts outside the execute step.
  a_scan_start_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |-> state_r == S_EXEC)
    else $error("scan started outside execute");

  // Every accepted beat reaches the execute step next.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_in |=> state_r == S_EXEC)
    else $error("accepted beat not executed");

  // A push always returns the controller to idle.
  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> state_r == S_IDLE)
    else $error("push did not return to idle");

endmodule

>>> hw/rtl/dict_enc_dp.sv
// Datapath of the dictionary encoder: item registers, entry count, scan, result and output.
module dict_enc_dp #(
  parameter int DICT_ENTRIES = dict_enc_pkg::DICT_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dict_enc_pkg::CMD_W-1:0]      in_command,
  input  logic signed [dict_enc_pkg::VALUE_W-1:0] in_value,
  input  logic [dict_enc_pkg::KEY_W-1:0]      in_key,
  input  dict_enc_pkg::dict_cmd_t              cmd,
  output dict_enc_pkg::dict_stat_t             stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dict_enc_pkg::KEY_W-1:0]      out_key_out,
  output logic signed [dict_enc_pkg::VALUE_W-1:0] out_value_out,
  output logic [dict_enc_pkg::STATUS_W-1:0]   out_status
);

  localparam int AW = $clog2(DICT_ENTRIES);
  localparam int CW = $clog2(DICT_ENTRIES + 1);
  localparam int KW = dict_enc_pkg::KEY_W;
  localparam int VW = dict_enc_pkg::VALUE_W;
  localparam int SW = dict_enc_pkg::STATUS_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DICT_ENTRIES);

  // Item registers
  logic [dict_enc_pkg::CMD_W-1:0] cmd_r;
  logic [VW-1:0]                  value_r;
  logic [KW-1:0]                  key_r;

  // Table state and scan
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_idx_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;

  // Result and output registers
  logic [KW-1:0] res_key_r, res_key_nxt;
  logic [VW-1:0] res_value_r, res_value_nxt;
  logic [SW-1:0] res_status_r, res_status_nxt;
  logic          out_valid_r;
  logic [KW-1:0] out_key_r;
  logic [VW-1:0] out_value_r;
  logic [SW-1:0] out_status_r;

  logic [CW+KW-1:0] key_wide, count_wide;
  logic [AW+KW-1:0] ins_key_wide, enc_key_wide;
  logic [AW-1:0]    raddr;
  logic [VW-1:0]    rdata;
  logic             scan_more;

  assign key_wide     = (CW+KW)'(key_r);
  assign count_wide   = (CW+KW)'(count_r);
  assign ins_key_wide = (AW+KW)'(count_r[AW-1:0]);
  assign enc_key_wide = (AW+KW)'(cmp_idx_r);
  assign scan_more    = (scan_idx_r < count_r);
  assign raddr        = cmd.dec_read ? key_wide[AW-1:0] : scan_idx_r[AW-1:0];

  dict_enc_ram #(
    .WIDTH(VW),
    .DEPTH(DICT_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.insert_wr),
    .waddr(count_r[AW-1:0]),
    .wdata(value_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    stat.command  = cmd_r;
    stat.full     = (count_r == FULL_COUNT);
    stat.key_ok   = (key_wide < count_wide);
    stat.hit      = cmp_vld_r && (rdata == value_r);
    stat.scan_end = !cmp_vld_r && !scan_more;
    stat.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    res_key_nxt    = '0;
    res_value_nxt  = '0;
    res_status_nxt = dict_enc_pkg::ST_ABSENT;
    unique case (cmd.res_sel)
      dict_enc_pkg::RES_INS_OK: begin
        res_key_nxt    = ins_key_wide[KW-1:0];
        res_status_nxt = dict_enc_pkg::ST_OK;
      end
      dict_enc_pkg::RES_FULL: begin
        res_status_nxt = dict_enc_pkg::ST_FULL;
      end
      dict_enc_pkg::RES_ENC_OK: begin
        res_key_nxt    = enc_key_wide[KW-1:0];
        res_status_nxt = dict_enc_pkg::ST_OK;
      end
      dict_enc_pkg::RES_DEC_OK: begin
        res_value_nxt  = rdata;
        res_status_nxt = dict_enc_pkg::ST_OK;
      end
      default: begin
        res_status_nxt = dict_enc_pkg::ST_ABSENT;
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r   <= in_command;
      value_r <= in_value;
      key_r   <= in_key;
    end
    if (cmd.scan_step && scan_more) begin
      cmp_idx_r <= scan_idx_r[AW-1:0];
    end
    if (cmd.res_load) begin
      res_key_r    <= res_key_nxt;
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
    end
    if (cmd.push) begin
      out_key_r    <= res_key_r;
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.insert_wr) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        cmp_vld_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_vld_r <= scan_more;
        if (scan_more) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_out   = out_key_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  // The entry count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond table size");

  // The entry count only ever grows by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> count_r == CW'($past(count_r) + 1'b1))
    else $error("entry count moved by other than one");

  // An insert is never written into a full table.
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert_wr |-> count_r != FULL_COUNT)
    else $error("insert written into full table");

  // A compared entry always lies below the count.
  a_cmp_written: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> CW'(cmp_idx_r) < count_r)
    else $error("compare on unwritten entry");

endmodule

>>> tb/tb.sv
// Self-checking testbench of the dictionary encoder core: insert, encode and decode traffic.
`timescale 1ns / 100ps

module tb;

  localparam int DICT_SIZE   = dict_enc_pkg::DICT_ENTRIES_DEF;
  localparam int RECUR_N     = 8;
  localparam int CYCLE_LIMIT = 1000000;
  // The package names no code for the fourth command; the block answers it as absent.
  localparam logic [dict_enc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [dict_enc_pkg::VALUE_W-1:0] VAL_MIN =
    {1'b1, {(dict_enc_pkg::VALUE_W-1){1'b0}}};
  localparam logic signed [dict_enc_pkg::VALUE_W-1:0] VAL_MAX =
    {1'b0, {(dict_enc_pkg::VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic [dict_enc_pkg::KEY_W-1:0]          key_out;
    logic signed [dict_enc_pkg::VALUE_W-1:0] value_out;
    logic [dict_enc_pkg::STATUS_W-1:0]       status;
  } dict_answer_t;

  logic                                    clk           = 1'b0;
  logic                                    rst_n         = 1'b0;
  logic                                    in_valid      = 1'b0;
  logic                                    in_ready;
  logic [dict_enc_pkg::CMD_W-1:0]          in_command    = dict_enc_pkg::CMD_INSERT;
  logic signed [dict_enc_pkg::VALUE_W-1:0] in_value      = '0;
  logic [dict_enc_pkg::KEY_W-1:0]          in_key        = '0;
  logic                                    out_valid;
  logic                                    out_ready     = 1'b0;
  logic [dict_enc_pkg::KEY_W-1:0]          out_key_out;
  logic signed [dict_enc_pkg::VALUE_W-1:0] out_value_out;
  logic [dict_enc_pkg::STATUS_W-1:0]       out_status;

  // Shadow copy of the table, updated in accept order.
  logic signed [dict_enc_pkg::VALUE_W-1:0] dict_vals [DICT_SIZE];
  int                                      dict_count = 0;
  // Small set of values that come back often, so inserts collide and encodes hit.
  logic signed [dict_enc_pkg::VALUE_W-1:0] recur_vals [RECUR_N];

  dict_answer_t pending_answers [$];
  int           error_count   = 0;
  int           cycle_count   = 0;
  int           send_idle_pct = 0;
  int           stall_pct     = 0;

  dictionary_encoder_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key_out   (out_key_out),
    .out_value_out (out_value_out),
    .out_status    (out_status)
  );

  always #6 clk = ~clk;

  // Compute the answer to one accepted beat and advance the shadow table.
  function automatic dict_answer_t dict_predict(
    input logic [dict_enc_pkg::CMD_W-1:0] cmd,
    input logic signed [dict_enc_pkg::VALUE_W-1:0] val,
    input logic [dict_enc_pkg::KEY_W-1:0] k);
    dict_answer_t ans;
    logic         found;
    ans.key_out   = '0;
    ans.value_out = '0;
    ans.status    = dict_enc_pkg::ST_ABSENT;
    found         = 1'b0;
    case (cmd)
      dict_enc_pkg::CMD_INSERT: begin
        if (dict_count >= DICT_SIZE) begin
          ans.status = dict_enc_pkg::ST_FULL;
        end else begin
          dict_vals[dict_count] = val;
          ans.key_out = dict_count[dict_enc_pkg::KEY_W-1:0];
          ans.status  = dict_enc_pkg::ST_OK;
          dict_count++;
        end
      end
      dict_enc_pkg::CMD_ENCODE: begin
        // Lowest matching key wins, so later hits are ignored once one is found.
        for (int i = 0; i < dict_count; i++) begin
          if (!found && dict_vals[i] == val) begin
            found       = 1'b1;
            ans.key_out = i[dict_enc_pkg::KEY_W-1:0];
            ans.status  = dict_enc_pkg::ST_OK;
          end
        end
      end
      dict_enc_pkg::CMD_DECODE: begin
        // Keys at or past the count are never read, only reported absent.
        if (int'(k) < dict_count) begin
          ans.value_out = dict_vals[k];
          ans.status    = dict_enc_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Pick a random key in 0..top, cut to the key width.
  function automatic logic [dict_enc_pkg::KEY_W-1:0] rand_key(input int unsigned top);
    int unsigned r;
    r = $urandom_range(top);
    return r[dict_enc_pkg::KEY_W-1:0];
  endfunction

  // Pick a value: a stored one with hit_pct chance, else a recurring one, else fresh bits.
  function automatic logic signed [dict_enc_pkg::VALUE_W-1:0] value_for(input int hit_pct);
    int r;
    r = $urandom_range(99);
    if (dict_count > 0 && r < hit_pct) return dict_vals[$urandom_range(dict_count - 1)];
    if (r < hit_pct + 20) return recur_vals[$urandom_range(RECUR_N - 1)];
    return {$urandom, $urandom};
  endfunction

  // Send one beat, holding valid and payload until accepted, then record its answer.
  task automatic send_beat(input logic [dict_enc_pkg::CMD_W-1:0] cmd,
                           input logic signed [dict_enc_pkg::VALUE_W-1:0] val,
                           input logic [dict_enc_pkg::KEY_W-1:0] k);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    in_key     <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers = {pending_answers, dict_predict(cmd, val, k)};
  endtask

  // Empty table: every lookup misses, and the unused command is refused.
  task automatic test_empty_table();
    send_beat(dict_enc_pkg::CMD_ENCODE, '0, '0);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd0);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd255);
    send_beat(CMD_UNUSED, -64'sd1, 8'd255);
  endtask

  // Extreme values, a duplicate insert, hits, misses and decode at the count boundary.
  task automatic test_extreme_values();
    send_beat(dict_enc_pkg::CMD_INSERT, VAL_MIN, 8'd0);
    send_beat(dict_enc_pkg::CMD_INSERT, VAL_MAX, 8'd0);
    send_beat(dict_enc_pkg::CMD_INSERT, '0, 8'd0);
    send_beat(dict_enc_pkg::CMD_INSERT, -64'sd1, 8'd0);
    send_beat(dict_enc_pkg::CMD_INSERT, VAL_MAX, 8'd255);
    send_beat(dict_enc_pkg::CMD_ENCODE, VAL_MAX, 8'd0);
    send_beat(dict_enc_pkg::CMD_ENCODE, -64'sd1, 8'd0);
    send_beat(dict_enc_pkg::CMD_ENCODE, VAL_MIN, 8'd0);
    send_beat(dict_enc_pkg::CMD_ENCODE, 64'sd1, 8'd0);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd4);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd0);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd3);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd5);
    send_beat(CMD_UNUSED, VAL_MAX, 8'd0);
  endtask

  // Mixed traffic in four idling modes; mostly hits, with misses and stray keys mixed in.
  task automatic test_random_traffic(input int beats_per_mode);
    int r;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < beats_per_mode; n++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          send_beat(dict_enc_pkg::CMD_INSERT, value_for(10), rand_key(255));
        end else if (r < 65) begin
          send_beat(dict_enc_pkg::CMD_ENCODE, value_for(65), rand_key(255));
        end else if (r < 95) begin
          if (dict_count > 0 && $urandom_range(99) < 70)
            send_beat(dict_enc_pkg::CMD_DECODE, {$urandom, $urandom},
                      rand_key(dict_count - 1));
          else
            send_beat(dict_enc_pkg::CMD_DECODE, {$urandom, $urandom}, rand_key(255));
        end else begin
          send_beat(CMD_UNUSED, {$urandom, $urandom}, rand_key(255));
        end
      end
    end
  endtask

  // Fill the table to the last slot, then poke it while full.
  task automatic test_fill_to_full();
    while (dict_count < DICT_SIZE)
      send_beat(dict_enc_pkg::CMD_INSERT, value_for(10), rand_key(255));
    send_beat(dict_enc_pkg::CMD_INSERT, VAL_MAX, 8'd0);
    send_beat(dict_enc_pkg::CMD_INSERT, {$urandom, $urandom}, 8'd255);
    send_beat(dict_enc_pkg::CMD_ENCODE, dict_vals[DICT_SIZE - 1], 8'd0);
    send_beat(dict_enc_pkg::CMD_DECODE, '0, 8'd255);
    send_beat(dict_enc_pkg::CMD_ENCODE, {$urandom, $urandom}, 8'd0);
  endtask

  // Receiver: stall at random per cycle according to the current mode.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result beat with the oldest pending answer, field by field.
  always @(posedge clk) begin : check_results
    dict_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("%0t: result beat with none pending: key %0d value %0d status %0d",
                 $time, out_key_out, out_value_out, out_status);
      end else begin
        want = pending_answers.pop_front();
        if (out_key_out !== want.key_out) begin
          error_count++;
          $display("%0t: key_out expected %0d actual %0d", $time, want.key_out, out_key_out);
        end
        if (out_value_out !== want.value_out) begin
          error_count++;
          $display("%0t: value_out expected %0d actual %0d",
                   $time, want.value_out, out_value_out);
        end
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs far past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_answers.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < RECUR_N; i++) recur_vals[i] = {$urandom, $urandom};
    // Hold reset, then release it at an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_extreme_values();
    test_random_traffic(90);
    test_fill_to_full();
    test_random_traffic(50);

    // Drain: drop valid, wait out every pending answer, then watch for strays.
    in_valid <= 1'b0;
    stall_pct = 9;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
